/* hdl/pmm_pkg.sv */
// ----------------------------------------------------------------------------
// pmm_pkg
// Shared types and constants of the paged memory manager.
// ----------------------------------------------------------------------------
package pmm_pkg;

    localparam int NUM_PROCS      = 16;
    localparam int PAGES_PER_PROC = 32;
    localparam int NUM_FRAMES     = 256;

    localparam int PID_W    = 4;
    localparam int PAGE_W   = 7;
    localparam int VPAGE_W  = 5;
    localparam int OFFS_W   = 10;
    localparam int FRAME_W  = 8;
    localparam int CNT_W    = 16;
    localparam int VA_W     = 17;
    localparam int COST_W   = 25;
    localparam int ADDR_W   = PID_W + VPAGE_W;
    localparam int DEPTH    = NUM_PROCS * PAGES_PER_PROC;
    localparam int IDX_W    = VPAGE_W + 1;
    localparam int CLR_W    = ADDR_W + 1;
    localparam int FREE_W   = FRAME_W + 1;
    localparam int MWORD_W  = 16;
    localparam int MWORDS   = NUM_FRAMES / MWORD_W;
    localparam int MSEL_W   = 4;
    localparam int MBIT_W   = 4;

    localparam logic [COST_W-1:0] HIT_NS  = COST_W'(10);
    localparam logic [COST_W-1:0] DISK_NS = COST_W'(14000000);

    localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TERM  = 2'd2,
        OP_ALT   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_HIT  = 3'd0,
        ST_FREE = 3'd1,
        ST_REPL = 3'd2,
        ST_SEGV = 3'd3,
        ST_WAIT = 3'd4,
        ST_TERM = 3'd5
    } t_status;

    typedef struct packed {
        logic                     present;
        logic                     dirty;
        logic [FRAME_W-1:0]       frame;
        logic signed [CNT_W-1:0]  cnt;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic    capture;
        logic    clear;
        logic    lookup;
        logic    hit;
        logic    search;
        logic    release_walk;
        logic    age_walk;
        logic    evict;
        logic    load;
        logic    emit;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic segv;
        logic term;
        logic present;
        logic free_avail;
        logic found;
        logic walk_done;
        logic have;
        logic out_free;
    } t_stat;

endpackage

/* hdl/pmm_if.sv */
// ----------------------------------------------------------------------------
// pmm_req_if / pmm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface pmm_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   opcode;
    logic [pmm_pkg::PID_W-1:0]    process_id;
    logic [pmm_pkg::PAGE_W-1:0]   page_number;
    logic [pmm_pkg::OFFS_W-1:0]   page_offset;

    modport source (output valid, opcode, process_id, page_number, page_offset,
                    input ready);
    modport sink   (input valid, opcode, process_id, page_number, page_offset,
                    output ready);
endinterface

interface pmm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [pmm_pkg::FRAME_W-1:0]  frame_index;
    logic [pmm_pkg::VA_W-1:0]     virtual_address;
    logic [pmm_pkg::VPAGE_W-1:0]  victim_page;
    logic                         victim_dirty;
    logic [pmm_pkg::COST_W-1:0]   cost_ns;

    modport source (output valid, status, frame_index, virtual_address, victim_page,
                    victim_dirty, cost_ns, input ready);
    modport sink   (input valid, status, frame_index, virtual_address, victim_page,
                    victim_dirty, cost_ns, output ready);
endinterface

/* hdl/pmm_ram.sv */
// ----------------------------------------------------------------------------
// pmm_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/pmm_ctrl.sv */
// ----------------------------------------------------------------------------
// pmm_ctrl
// Request sequencer: lookup, free frame search, release and aging walks.
// ----------------------------------------------------------------------------
module pmm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  pmm_pkg::t_stat   i_stat,
    output pmm_pkg::t_cmd    o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR   = 10'b0000000001,
        S_IDLE    = 10'b0000000010,
        S_READ    = 10'b0000000100,
        S_CHECK   = 10'b0000001000,
        S_SEARCH  = 10'b0000010000,
        S_RELEASE = 10'b0000100000,
        S_AGE     = 10'b0001000000,
        S_EVICT   = 10'b0010000000,
        S_LOAD    = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    pmm_pkg::t_status r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= pmm_pkg::ST_HIT;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.lookup = 1'b1;
                if (i_stat.segv) begin
                    n_code  = pmm_pkg::ST_SEGV;
                    n_state = S_RELEASE;
                end else if (i_stat.term) begin
                    n_code  = pmm_pkg::ST_TERM;
                    n_state = S_RELEASE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.present) begin
                    o_cmd.hit = 1'b1;
                    n_code  = pmm_pkg::ST_HIT;
                    n_state = S_DONE;
                end else if (i_stat.free_avail) begin
                    n_code  = pmm_pkg::ST_FREE;
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_AGE;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                if (i_stat.found) begin
                    n_state = S_LOAD;
                end
            end
            S_RELEASE: begin
                o_cmd.release_walk = 1'b1;
                if (i_stat.walk_done) begin
                    n_state = S_DONE;
                end
            end
            S_AGE: begin
                o_cmd.age_walk = 1'b1;
                if (i_stat.walk_done) begin
                    if (i_stat.have) begin
                        n_code  = pmm_pkg::ST_REPL;
                        n_state = S_EVICT;
                    end else begin
                        n_code  = pmm_pkg::ST_WAIT;
                        n_state = S_DONE;
                    end
                end
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/pmm_dp.sv */
// ----------------------------------------------------------------------------
// pmm_dp
// Page table memory, frame map, walk counters and result register.
// ----------------------------------------------------------------------------
module pmm_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pmm_pkg::t_cmd  i_cmd,
    output pmm_pkg::t_stat o_stat,
    pmm_req_if.sink        i_req,
    pmm_rsp_if.source      o_rsp
);

    // request
    logic [1:0]                   r_op;
    logic [pmm_pkg::PID_W-1:0]    r_pid;
    logic [pmm_pkg::PAGE_W-1:0]   r_page;
    logic [pmm_pkg::OFFS_W-1:0]   r_offs;

    // walk / search / clear
    logic [pmm_pkg::CLR_W-1:0]    r_clr;
    logic [pmm_pkg::IDX_W-1:0]    r_idx;
    logic                         r_rd_vld;
    logic [pmm_pkg::VPAGE_W-1:0]  r_rd_idx;
    logic [pmm_pkg::MSEL_W-1:0]   r_sw;

    // victim tracking
    logic                                 r_have;
    logic signed [pmm_pkg::CNT_W-1:0]     r_best;
    logic [pmm_pkg::VPAGE_W-1:0]          r_vic;
    logic                                 r_vic_dirty;
    logic [pmm_pkg::FRAME_W-1:0]          r_vic_frame;
    logic [pmm_pkg::FRAME_W-1:0]          r_frame;

    logic [pmm_pkg::NUM_FRAMES-1:0]       r_map;
    logic [pmm_pkg::FREE_W-1:0]           r_free;

    // output register
    logic                          r_o_valid;
    logic [2:0]                    r_o_status;
    logic [pmm_pkg::FRAME_W-1:0]   r_o_frame;
    logic [pmm_pkg::VA_W-1:0]      r_o_va;
    logic [pmm_pkg::VPAGE_W-1:0]   r_o_vpage;
    logic                          r_o_vdirty;
    logic [pmm_pkg::COST_W-1:0]    r_o_cost;

    // memory ports
    logic                          ram_we;
    logic [pmm_pkg::ADDR_W-1:0]    ram_waddr;
    pmm_pkg::t_entry               ram_wdata;
    logic [pmm_pkg::ADDR_W-1:0]    ram_raddr;
    logic [pmm_pkg::ENTRY_W-1:0]   ram_rdata;
    pmm_pkg::t_entry               rd;

    logic [pmm_pkg::ADDR_W-1:0]    req_addr;
    logic [pmm_pkg::MWORD_W-1:0]   free_word;
    logic [pmm_pkg::MBIT_W-1:0]    free_bit;
    logic                          walking;
    logic                          walk_issue;
    logic signed [pmm_pkg::CNT_W-1:0] aged_cnt;
    logic signed [pmm_pkg::CNT_W-1:0] hit_cnt;

    pmm_ram #(
        .WIDTH (pmm_pkg::ENTRY_W),
        .DEPTH (pmm_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd         = pmm_pkg::t_entry'(ram_rdata);
    assign req_addr   = {r_pid, r_page[pmm_pkg::VPAGE_W-1:0]};
    assign walking    = i_cmd.release_walk | i_cmd.age_walk;
    assign walk_issue = walking & ~r_idx[pmm_pkg::IDX_W-1];
    assign aged_cnt   = (rd.cnt == pmm_pkg::CNT_MIN) ? rd.cnt : rd.cnt - 16'sd1;
    assign hit_cnt    = (rd.cnt == pmm_pkg::CNT_MAX) ? rd.cnt : rd.cnt + 16'sd1;

    always_comb begin
        free_word = ~r_map[r_sw*pmm_pkg::MWORD_W +: pmm_pkg::MWORD_W];
        free_bit  = '0;
        for (int b = pmm_pkg::MWORD_W - 1; b >= 0; b--) begin
            if (free_word[b]) begin
                free_bit = pmm_pkg::MBIT_W'(b);
            end
        end
    end

    always_comb begin
        ram_raddr = walk_issue ? {r_pid, r_idx[pmm_pkg::VPAGE_W-1:0]} : req_addr;
        ram_we    = 1'b0;
        ram_waddr = req_addr;
        ram_wdata = '0;
        if (i_cmd.clear) begin
            ram_we    = ~r_clr[pmm_pkg::CLR_W-1];
            ram_waddr = r_clr[pmm_pkg::ADDR_W-1:0];
        end else if (i_cmd.release_walk && r_rd_vld) begin
            ram_we    = 1'b1;
            ram_waddr = {r_pid, r_rd_idx};
        end else if (i_cmd.age_walk && r_rd_vld) begin
            ram_we    = rd.present;
            ram_waddr = {r_pid, r_rd_idx};
            ram_wdata = rd;
            ram_wdata.cnt = aged_cnt;
        end else if (i_cmd.hit) begin
            ram_we    = 1'b1;
            ram_wdata = rd;
            ram_wdata.cnt = hit_cnt;
            ram_wdata.dirty = rd.dirty | (r_op == pmm_pkg::OP_WRITE);
        end else if (i_cmd.evict) begin
            ram_we    = 1'b1;
            ram_waddr = {r_pid, r_vic};
        end else if (i_cmd.load) begin
            ram_we    = 1'b1;
            ram_wdata.present = 1'b1;
            ram_wdata.dirty   = (r_op == pmm_pkg::OP_WRITE);
            ram_wdata.frame   = r_frame;
            ram_wdata.cnt     = 16'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_map     <= '0;
            r_free    <= pmm_pkg::FREE_W'(pmm_pkg::NUM_FRAMES);
            r_o_valid <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_idx     <= '0;
            r_sw      <= '0;
            r_have    <= 1'b0;
        end else begin
            if (i_cmd.clear && !r_clr[pmm_pkg::CLR_W-1]) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.lookup) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_sw     <= '0;
                r_have   <= 1'b0;
            end else if (walking) begin
                r_rd_vld <= walk_issue;
                r_rd_idx <= r_idx[pmm_pkg::VPAGE_W-1:0];
                if (walk_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.release_walk && r_rd_vld && rd.present && r_map[rd.frame]) begin
                r_map[rd.frame] <= 1'b0;
                r_free <= r_free + 1'b1;
            end
            if (i_cmd.age_walk && r_rd_vld && rd.present) begin
                if (!r_have || aged_cnt < r_best) begin
                    r_have      <= 1'b1;
                    r_best      <= aged_cnt;
                    r_vic       <= r_rd_idx;
                    r_vic_dirty <= rd.dirty;
                    r_vic_frame <= rd.frame;
                end
            end
            if (i_cmd.search) begin
                if (|free_word) begin
                    r_frame <= {r_sw, free_bit};
                    r_map[{r_sw, free_bit}] <= 1'b1;
                    r_free <= r_free - 1'b1;
                end else begin
                    r_sw <= r_sw + 1'b1;
                end
            end
            if (i_cmd.hit) begin
                r_frame <= rd.frame;
            end
            if (i_cmd.evict) begin
                r_frame <= r_vic_frame;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_req.opcode;
            r_pid  <= i_req.process_id;
            r_page <= i_req.page_number;
            r_offs <= i_req.page_offset;
        end
        if (i_cmd.emit) begin
            r_o_status <= i_cmd.code;
            r_o_va     <= {r_page, r_offs};
            r_o_frame  <= '0;
            r_o_vpage  <= '0;
            r_o_vdirty <= 1'b0;
            r_o_cost   <= '0;
            case (i_cmd.code)
                pmm_pkg::ST_HIT: begin
                    r_o_frame <= r_frame;
                    r_o_cost  <= pmm_pkg::HIT_NS;
                end
                pmm_pkg::ST_FREE: begin
                    r_o_frame <= r_frame;
                    r_o_cost  <= pmm_pkg::DISK_NS;
                end
                pmm_pkg::ST_REPL: begin
                    r_o_frame  <= r_frame;
                    r_o_vpage  <= r_vic;
                    r_o_vdirty <= r_vic_dirty;
                    r_o_cost   <= r_vic_dirty ? pmm_pkg::DISK_NS + pmm_pkg::DISK_NS
                                              : pmm_pkg::DISK_NS;
                end
                default: begin
                    r_o_frame <= '0;
                end
            endcase
        end
    end

    assign o_stat.clear_done = r_clr[pmm_pkg::CLR_W-1];
    assign o_stat.segv       = (r_page[pmm_pkg::PAGE_W-1:pmm_pkg::VPAGE_W] != '0);
    assign o_stat.term       = (r_op == pmm_pkg::OP_TERM);
    assign o_stat.present    = rd.present;
    assign o_stat.free_avail = (r_free != '0);
    assign o_stat.found      = |free_word;
    assign o_stat.walk_done  = r_idx[pmm_pkg::IDX_W-1] & ~r_rd_vld;
    assign o_stat.have       = r_have;
    assign o_stat.out_free   = ~r_o_valid | o_rsp.ready;

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.frame_index     = r_o_frame;
    assign o_rsp.virtual_address = r_o_va;
    assign o_rsp.victim_page     = r_o_vpage;
    assign o_rsp.victim_dirty    = r_o_vdirty;
    assign o_rsp.cost_ns         = r_o_cost;

`ifndef ASSERT_OFF
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= pmm_pkg::FREE_W'(pmm_pkg::NUM_FRAMES))
        else $error("free frame count above frame total");
    a_search_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.search |-> (r_free != '0))
        else $error("frame search with no free frame");
    a_found_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.search && (|free_word)) |=> r_map[r_frame])
        else $error("allocated frame not marked in use");
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clear, i_cmd.hit, i_cmd.evict, i_cmd.load, walking}))
        else $error("conflicting table writes");
`endif

endmodule

/* hdl/paged_memory_manager_top.sv */
// ----------------------------------------------------------------------------
// paged_memory_manager_top
// Demand-paged memory manager with aging replacement.
// ----------------------------------------------------------------------------
// One request is handled at a time; its result sits in an output register so
// the next request is taken while the result waits. After reset the page table
// is cleared, with no request accepted. A miss into a free frame scans the free
// frame map 16 frames a cycle; replacement, terminate and segmentation fault
// walk the 32 table entries of the process through the single read port of the
// page table memory.
module paged_memory_manager_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pmm_req_if.sink   i_req,
    pmm_rsp_if.source o_rsp
);

    pmm_pkg::t_cmd  cmd;
    pmm_pkg::t_stat stat;
    logic           req_ready;

    pmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pmm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

    assign i_req.ready = req_ready;

endmodule
